// ----- design/dls_pkg.sv -----
// Package for the decimal long subtractor: digit widths, request codes,
// sequencer states and the serial subtractor control struct. No dependencies.
package dls_pkg;

    localparam int MAX_DIGITS_DEF = 64;
    localparam int DIGIT_W        = 4;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [DIGIT_W:0]   DEC_BASE  = 5'd10;

    localparam logic REQ_FIRST  = 1'b0;
    localparam logic REQ_SECOND = 1'b1;

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_RD   = 6'b000010,
        S_SUB  = 6'b000100,
        S_ERD  = 6'b001000,
        S_EMIT = 6'b010000,
        S_ERR  = 6'b100000
    } t_state;

    typedef struct packed {
        logic clr;
        logic en;
    } t_sub_ctrl;

endpackage

// ----- design/dls_if.sv -----
// Valid/ready channel interfaces for the decimal long subtractor.
// Depends on dls_pkg for the digit width.
interface dls_in_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [dls_pkg::DIGIT_W-1:0]  digit_in;
    logic                         operand_end;

    modport source (output valid, output req_type, output digit_in, output operand_end,
                    input ready);
    modport sink   (input valid, input req_type, input digit_in, input operand_end,
                    output ready);
endinterface

interface dls_out_if;
    logic                         valid;
    logic                         ready;
    logic [dls_pkg::DIGIT_W-1:0]  result_digit;
    logic                         is_negative;
    logic                         is_last;
    logic                         too_long;

    modport source (output valid, output result_digit, output is_negative,
                    output is_last, output too_long, input ready);
    modport sink   (input valid, input result_digit, input is_negative,
                    input is_last, input too_long, output ready);
endinterface

// ----- design/dls_digit_ram.sv -----
// Digit store: one write port, one registered read port.
// Depends on dls_pkg for the digit width.
module dls_digit_ram #(
    parameter int DEPTH = dls_pkg::MAX_DIGITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [dls_pkg::DIGIT_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [dls_pkg::DIGIT_W-1:0]  o_rdata
);
    import dls_pkg::*;

    logic [DIGIT_W-1:0] r_mem [DEPTH];
    logic [DIGIT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/dls_serial_sub.sv -----
// Digit-serial decimal subtractor: forms a-b and b-a one digit per step,
// least significant first, keeping both borrows. Depends on dls_pkg.
module dls_serial_sub (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dls_pkg::t_sub_ctrl           i_ctrl,
    input  logic [dls_pkg::DIGIT_W-1:0]  i_a,
    input  logic [dls_pkg::DIGIT_W-1:0]  i_b,
    output logic [dls_pkg::DIGIT_W-1:0]  o_diff_ab,
    output logic [dls_pkg::DIGIT_W-1:0]  o_diff_ba,
    output logic                         o_borrow_ab
);
    import dls_pkg::*;

    logic             r_borrow_ab;
    logic             r_borrow_ba;
    logic [DIGIT_W:0] raw_ab;
    logic [DIGIT_W:0] raw_ba;
    logic [DIGIT_W:0] fix_ab;
    logic [DIGIT_W:0] fix_ba;

    always_comb begin
        raw_ab = {1'b0, i_a} - {1'b0, i_b} - {{DIGIT_W{1'b0}}, r_borrow_ab};
        raw_ba = {1'b0, i_b} - {1'b0, i_a} - {{DIGIT_W{1'b0}}, r_borrow_ba};
        // add the base back when the digit went negative
        fix_ab = raw_ab[DIGIT_W] ? raw_ab + DEC_BASE : raw_ab;
        fix_ba = raw_ba[DIGIT_W] ? raw_ba + DEC_BASE : raw_ba;
        o_diff_ab = fix_ab[DIGIT_W-1:0];
        o_diff_ba = fix_ba[DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_borrow_ab <= 1'b0;
            r_borrow_ba <= 1'b0;
        end else if (i_ctrl.clr) begin
            r_borrow_ab <= 1'b0;
            r_borrow_ba <= 1'b0;
        end else if (i_ctrl.en) begin
            r_borrow_ab <= raw_ab[DIGIT_W];
            r_borrow_ba <= raw_ba[DIGIT_W];
        end
    end

    // final borrow of a-b is set exactly when b > a
    assign o_borrow_ab = r_borrow_ab;

endmodule

// ----- design/decimal_long_subtractor.sv -----
// Decimal long subtractor, sign-magnitude, digit serial.
// Depends on dls_pkg, dls_if, dls_digit_ram and dls_serial_sub.
//
// Usage:
//   i_in carries one decimal digit per item, most significant first. Send the
//   whole first operand (req_type 0), then the second (req_type 1); mark the
//   final digit of each with operand_end. A digit above nine counts as nine.
//   A first-operand digit while the second is loading abandons the problem.
//   o_out carries the answer, one digit per item, most significant first, as
//   many as the longer operand, is_last on the final one, is_negative when
//   the second operand was larger. An operand over MAX_DIGITS yields one item
//   with too_long set instead.
// Timing:
//   Digits load while the block is in its load state. After the last digit, the serial
//   subtractor walks the aligned digits least significant first, each digit
//   by a registered store read, then subtract and write back; then the
//   answer is read back, each digit by a store read, then emit. The input
//   is held off during the walk and the read-back. A stalled receiver
//   holds the output register and the read-back; input digits are taken
//   while a result still waits.
// Reset: state, counts, phase, overflow and the output valid clear; stores need none.
module decimal_long_subtractor #(
    parameter int MAX_DIGITS = dls_pkg::MAX_DIGITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dls_in_if.sink       i_in,
    dls_out_if.source    o_out
);
    import dls_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_DIGITS);

    // control state
    t_state         r_state, n_state;
    logic [CW-1:0]  r_first_cnt, n_first_cnt;
    logic [CW-1:0]  r_second_cnt, n_second_cnt;
    logic           r_ovf, n_ovf;
    logic           r_phase, n_phase;
    logic           r_out_valid, n_out_valid;

    // problem walk registers
    logic [CW-1:0]  r_len, n_len;
    logic [CW-1:0]  r_off1, n_off1;
    logic [CW-1:0]  r_off2, n_off2;
    logic [AW-1:0]  r_p, n_p;
    logic [AW-1:0]  r_q, n_q;
    logic           r_z1, n_z1;
    logic           r_z2, n_z2;

    // output payload
    logic [DIGIT_W-1:0] r_out_digit, n_out_digit;
    logic               r_out_neg, n_out_neg;
    logic               r_out_last, n_out_last;
    logic               r_out_err, n_out_err;

    // store ports
    logic               we1, we2, re1, re2;
    logic [AW-1:0]      waddr1, waddr2, raddr1, raddr2;
    logic [DIGIT_W-1:0] wdata1, wdata2, rdata1, rdata2;

    // subtractor
    t_sub_ctrl          sub_ctrl;
    logic [DIGIT_W-1:0] sub_a, sub_b, diff_ab, diff_ba;
    logic               sub_neg;

    // accept-time helpers
    logic               in_acc;
    logic               out_free;
    logic [DIGIT_W-1:0] dsat;
    logic [CW-1:0]      base1, base2, sec_new, len_new;
    logic               ovf_base, ovf2;
    logic [AW-1:0]      last_idx;

    assign i_in.ready = (r_state == S_LOAD);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign dsat       = (i_in.digit_in > DIGIT_MAX) ? DIGIT_MAX : i_in.digit_in;
    assign last_idx   = AW'(r_len - CW'(1));
    assign sub_a      = r_z1 ? '0 : rdata1;
    assign sub_b      = r_z2 ? '0 : rdata2;

    always_comb begin
        n_state      = r_state;
        n_first_cnt  = r_first_cnt;
        n_second_cnt = r_second_cnt;
        n_ovf        = r_ovf;
        n_phase      = r_phase;
        n_len        = r_len;
        n_off1       = r_off1;
        n_off2       = r_off2;
        n_p          = r_p;
        n_q          = r_q;
        n_z1         = r_z1;
        n_z2         = r_z2;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_digit  = r_out_digit;
        n_out_neg    = r_out_neg;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;
        we1          = 1'b0;
        we2          = 1'b0;
        re1          = 1'b0;
        re2          = 1'b0;
        waddr1       = r_p;
        waddr2       = r_p;
        wdata1       = dsat;
        wdata2       = dsat;
        raddr1       = r_q;
        raddr2       = r_q;
        sub_ctrl     = '0;
        base1        = r_phase ? '0 : r_first_cnt;
        base2        = r_phase ? r_second_cnt : '0;
        ovf_base     = r_phase ? 1'b0 : r_ovf;
        sec_new      = (base2 != CNT_FULL) ? base2 + CW'(1) : base2;
        ovf2         = r_ovf || (base2 == CNT_FULL);
        len_new      = (r_first_cnt > sec_new) ? r_first_cnt : sec_new;

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (i_in.req_type == REQ_FIRST) begin
                        // restart if a second operand was under way
                        if (base1 != CNT_FULL) begin
                            we1         = 1'b1;
                            waddr1      = base1[AW-1:0];
                            n_first_cnt = base1 + CW'(1);
                            n_ovf       = ovf_base;
                        end else begin
                            n_first_cnt = base1;
                            n_ovf       = 1'b1;
                        end
                        n_second_cnt = '0;
                        n_phase      = i_in.operand_end;
                    end else begin
                        n_phase = 1'b1;
                        if (base2 != CNT_FULL) begin
                            we2    = 1'b1;
                            waddr2 = base2[AW-1:0];
                        end
                        n_second_cnt = sec_new;
                        n_ovf        = ovf2;
                        if (i_in.operand_end) begin
                            n_first_cnt  = '0;
                            n_second_cnt = '0;
                            n_ovf        = 1'b0;
                            n_phase      = 1'b0;
                            if (ovf2) begin
                                n_state = S_ERR;
                            end else begin
                                n_len        = len_new;
                                n_off1       = len_new - r_first_cnt;
                                n_off2       = len_new - sec_new;
                                n_p          = AW'(len_new - CW'(1));
                                sub_ctrl.clr = 1'b1;
                                n_state      = S_RD;
                            end
                        end
                    end
                end
            end
            S_RD: begin
                // fetch the aligned digits of position p, zero above the operand
                re1     = 1'b1;
                re2     = 1'b1;
                raddr1  = AW'(CW'(r_p) - r_off1);
                raddr2  = AW'(CW'(r_p) - r_off2);
                n_z1    = CW'(r_p) < r_off1;
                n_z2    = CW'(r_p) < r_off2;
                n_state = S_SUB;
            end
            S_SUB: begin
                // write both differences back at position p
                sub_ctrl.en = 1'b1;
                we1         = 1'b1;
                we2         = 1'b1;
                wdata1      = diff_ab;
                wdata2      = diff_ba;
                if (r_p == '0) begin
                    n_q     = '0;
                    n_state = S_ERD;
                end else begin
                    n_p     = r_p - AW'(1);
                    n_state = S_RD;
                end
            end
            S_ERD: begin
                re1     = 1'b1;
                re2     = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_digit = sub_neg ? rdata2 : rdata1;
                    n_out_neg   = sub_neg;
                    n_out_last  = (r_q == last_idx);
                    n_out_err   = 1'b0;
                    if (r_q == last_idx) begin
                        n_state = S_LOAD;
                    end else begin
                        n_q     = r_q + AW'(1);
                        n_state = S_ERD;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_digit = '0;
                    n_out_neg   = 1'b0;
                    n_out_last  = 1'b1;
                    n_out_err   = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_ovf        <= 1'b0;
            r_phase      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_first_cnt  <= n_first_cnt;
            r_second_cnt <= n_second_cnt;
            r_ovf        <= n_ovf;
            r_phase      <= n_phase;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_off1      <= n_off1;
        r_off2      <= n_off2;
        r_p         <= n_p;
        r_q         <= n_q;
        r_z1        <= n_z1;
        r_z2        <= n_z2;
        r_out_digit <= n_out_digit;
        r_out_neg   <= n_out_neg;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
    end

    dls_digit_ram #(.DEPTH(MAX_DIGITS)) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr1),
        .i_wdata (wdata1),
        .i_re    (re1),
        .i_raddr (raddr1),
        .o_rdata (rdata1)
    );

    dls_digit_ram #(.DEPTH(MAX_DIGITS)) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (waddr2),
        .i_wdata (wdata2),
        .i_re    (re2),
        .i_raddr (raddr2),
        .o_rdata (rdata2)
    );

    dls_serial_sub u_sub (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (sub_ctrl),
        .i_a         (sub_a),
        .i_b         (sub_b),
        .o_diff_ab   (diff_ab),
        .o_diff_ba   (diff_ba),
        .o_borrow_ab (sub_neg)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.result_digit = r_out_digit;
    assign o_out.is_negative  = r_out_neg;
    assign o_out.is_last      = r_out_last;
    assign o_out.too_long     = r_out_err;

endmodule
